// ===== hw/rtl/lpv_pkg.sv =====
// shared types and constants of the scheduled inverse iir filter
`default_nettype none
package lpv_pkg;

    localparam int N_POINTS    = 8;
    localparam int SLOT_W      = 3;
    localparam int NA_MAX      = 8;
    localparam int NB_MAX      = 7;
    localparam int DLY_MAX     = 7;
    localparam int HIST_LEN    = NA_MAX + DLY_MAX;
    localparam int COEF_IDX_W  = 3;
    localparam int COEF_ADDR_W = SLOT_W + COEF_IDX_W;
    localparam int COEF_DEPTH  = 1 << COEF_ADDR_W;
    localparam int NUM_W       = 52;
    localparam int DVD_W       = NUM_W + 16;
    localparam int STEP_W      = 7;
    localparam int FRAC_W      = 30;
    localparam int PADDR_W     = 3;

    typedef enum logic [2:0] {
        MODE_SAMPLE  = 3'd0,
        MODE_KEY     = 3'd1,
        MODE_DELAY   = 3'd2,
        MODE_COEF_A  = 3'd3,
        MODE_COEF_B  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_B0_ZERO = 2'd2,
        ST_SAT     = 2'd3
    } t_status;

    localparam logic [PADDR_W-3:0] REG_OUTPUT_ORDER = 1'b0;
    localparam logic [PADDR_W-3:0] REG_INPUT_ORDER  = 1'b1;

    typedef struct packed {
        logic [3:0] output_order;
        logic [2:0] input_order;
    } t_cfg;

    typedef struct packed {
        logic                   en;
        logic                   sel_b;
        logic [COEF_ADDR_W-1:0] addr;
        logic [31:0]            data;
    } t_coef_wr;

endpackage
`default_nettype wire

// ===== hw/rtl/lpv_stream_if.sv =====
// valid/ready channels for sample/load items and drive results
`default_nettype none
interface lpv_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic signed [31:0] y_current;
    logic signed [31:0] y_ahead;
    logic signed [31:0] sched_param;
    logic [2:0]         slot;
    logic [2:0]         coef_index;
    logic signed [31:0] load_value;

    modport source (output valid, mode, y_current, y_ahead, sched_param, slot, coef_index,
                    load_value, input ready);
    modport sink   (input valid, mode, y_current, y_ahead, sched_param, slot, coef_index,
                    load_value, output ready);
endinterface

interface lpv_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive_value;
    logic [1:0]         status;

    modport source (output valid, drive_value, status, input ready);
    modport sink   (input valid, drive_value, status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lpv_cfg.sv =====
// apb register file for the model orders
`default_nettype none
module lpv_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lpv_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output lpv_pkg::t_cfg                    o_cfg
);
    lpv_pkg::t_cfg r_cfg;
    logic [lpv_pkg::PADDR_W-3:0] w_idx;

    assign w_idx  = paddr[lpv_pkg::PADDR_W-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.output_order <= 4'd2;
            r_cfg.input_order  <= 3'd2;
        end else if (psel && penable && pwrite) begin
            if (w_idx == lpv_pkg::REG_OUTPUT_ORDER) begin
                r_cfg.output_order <= pwdata[3:0];
            end else begin
                r_cfg.input_order <= pwdata[2:0];
            end
        end
    end

    always_comb begin
        if (w_idx == lpv_pkg::REG_OUTPUT_ORDER) begin
            prdata = {28'd0, r_cfg.output_order};
        end else begin
            prdata = {29'd0, r_cfg.input_order};
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/lpv_div.sv =====
// shared radix-2 restoring divider, dividend fed msb first
`default_nettype none
module lpv_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [lpv_pkg::DVD_W-1:0]  i_dividend,
    input  wire logic [31:0]                i_divisor,
    input  wire logic [lpv_pkg::STEP_W-1:0] i_steps,
    output logic                            o_done,
    output logic [32:0]                     o_quot,
    output logic                            o_ovf
);
    logic [lpv_pkg::DVD_W-1:0]  r_dvd;
    logic [31:0]                r_dvs;
    logic [31:0]                r_rem;
    logic [32:0]                r_quot;
    logic                       r_ovf;
    logic [lpv_pkg::STEP_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [32:0]                w_rem2;
    logic [32:0]                w_diff;
    logic                       w_ge;

    assign w_rem2 = {r_rem, r_dvd[lpv_pkg::DVD_W-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_dvs};
    assign w_diff = w_rem2 - {1'b0, r_dvs};
    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
                r_quot <= '0;
                r_ovf  <= 1'b0;
                r_cnt  <= i_steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_dvd  <= r_dvd << 1;
                r_rem  <= w_ge ? w_diff[31:0] : w_rem2[31:0];
                // quotient bits falling off the top mean saturation anyway
                r_ovf  <= r_ovf | r_quot[32];
                r_quot <= {r_quot[31:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == lpv_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/lpv_coef_mem.sv =====
// a and b coefficient memories, two registered read ports each
`default_nettype none
module lpv_coef_mem (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire lpv_pkg::t_coef_wr               i_wr,
    input  wire logic [lpv_pkg::COEF_ADDR_W-1:0] i_addr_lo,
    input  wire logic [lpv_pkg::COEF_ADDR_W-1:0] i_addr_hi,
    output logic signed [31:0]                   o_a_lo,
    output logic signed [31:0]                   o_a_hi,
    output logic signed [31:0]                   o_b_lo,
    output logic signed [31:0]                   o_b_hi
);
    logic [31:0] r_a_mem [lpv_pkg::COEF_DEPTH];
    logic [31:0] r_b_mem [lpv_pkg::COEF_DEPTH];
    logic [lpv_pkg::COEF_DEPTH-1:0] r_a_vld;
    logic [lpv_pkg::COEF_DEPTH-1:0] r_b_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && !i_wr.sel_b) begin
            r_a_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_wr.en && i_wr.sel_b) begin
            r_b_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= '0;
            r_b_vld <= '0;
        end else if (i_wr.en) begin
            if (i_wr.sel_b) begin
                r_b_vld[i_wr.addr] <= 1'b1;
            end else begin
                r_a_vld[i_wr.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_a_lo <= r_a_vld[i_addr_lo] ? r_a_mem[i_addr_lo] : 32'sd0;
        o_a_hi <= r_a_vld[i_addr_hi] ? r_a_mem[i_addr_hi] : 32'sd0;
        o_b_lo <= r_b_vld[i_addr_lo] ? r_b_mem[i_addr_lo] : 32'sd0;
        o_b_hi <= r_b_vld[i_addr_hi] ? r_b_mem[i_addr_hi] : 32'sd0;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/lpv_inverse_iir_filter_unit.sv =====
// top level of the gain-scheduled inverse arx filter
`default_nettype none
// Takes one item at a time. A load item (key, delay or coefficient write) goes through
// S_DONE into the output register as soon as that register is free. A sample item scans
// the eight model points and runs the shared bit-serial divider for the interpolation
// fraction when p lies strictly between two keys. It then interpolates and accumulates
// the 16 coefficients one at a time through the coefficient memories in the steps
// S_RD, S_LMUL, S_LADD, S_MMUL and S_MACC. Last it runs the divider again for x = num / b0
// when b0 is not zero. The next item is taken in the cycle after its predecessor's result
// enters the output register, while that result may still wait there. A result still
// held there stalls the following one.
module lpv_inverse_iir_filter_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    lpv_in_if.sink                           i_in,
    lpv_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lpv_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_PICK, S_TWAIT, S_DELAY, S_RD, S_LMUL, S_LADD,
        S_MMUL, S_MACC, S_XCHK, S_XWAIT, S_DONE
    } t_state;

    t_state r_state;

    lpv_pkg::t_cfg     w_cfg;
    lpv_pkg::t_coef_wr w_wr;

    // point table
    logic signed [31:0] r_key  [lpv_pkg::N_POINTS];
    logic [2:0]         r_pdly [lpv_pkg::N_POINTS];
    logic [lpv_pkg::N_POINTS-1:0] r_pvalid;

    // histories
    logic signed [31:0] r_th [lpv_pkg::HIST_LEN];
    logic signed [31:0] r_dh [lpv_pkg::NB_MAX];

    // sample operands and search results
    logic signed [31:0] r_yc, r_ya, r_p;
    logic [lpv_pkg::SLOT_W-1:0] r_k, r_ex_slot, r_lo_slot, r_hi_slot;
    logic               r_ex_ok, r_lo_ok, r_hi_ok;
    logic signed [31:0] r_lo_key, r_hi_key;
    logic [2:0]         r_ex_dly, r_lo_dly, r_hi_dly;
    logic [lpv_pkg::FRAC_W-1:0] r_t;
    logic [2:0]         r_d;
    logic [4:0]         r_len;
    logic [3:0]         r_j;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_coef;
    logic signed [31:0] r_b0;
    logic               r_act, r_sub, r_neg;
    logic signed [lpv_pkg::NUM_W-1:0] r_num;

    // divider request
    logic                       r_div_start;
    logic [lpv_pkg::DVD_W-1:0]  r_div_dvd;
    logic [31:0]                r_div_dvs;
    logic [lpv_pkg::STEP_W-1:0] r_div_steps;
    logic                       w_div_done;
    logic [32:0]                w_quot;
    logic                       w_ovf;

    // result and output register
    logic signed [31:0] r_res_val;
    logic [1:0]         r_res_st;
    logic               r_out_valid;
    logic signed [31:0] r_out_val;
    logic [1:0]         r_out_st;

    logic signed [31:0] w_a_lo, w_a_hi, w_b_lo, w_b_hi;
    logic signed [31:0] w_v0, w_v1;
    logic signed [32:0] w_diff;
    logic signed [63:0] w_lr;
    logic signed [63:0] w_term;
    logic [3:0]         w_na;
    logic [2:0]         w_nb;
    logic [3:0]         w_k;
    logic [3:0]         w_hidx;
    logic [2:0]         w_bi;
    logic [2:0]         w_didx;
    logic signed [31:0] w_yv;
    logic               w_act;
    logic signed [4:0]  w_ddiff;
    logic signed [36:0] w_dprod;
    logic signed [36:0] w_dround;
    logic [2:0]         w_d;
    logic [31:0]        w_dp, w_span;
    logic [lpv_pkg::NUM_W-1:0] w_mag;
    logic [31:0]        w_dm;
    logic               w_big;
    logic signed [31:0] w_x;
    logic               w_sat;
    logic               w_accept;
    logic [2:0]         w_lv_dly;

    lpv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lpv_coef_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_addr_lo ({r_lo_slot, r_j[2:0]}),
        .i_addr_hi ({r_hi_slot, r_j[2:0]}),
        .o_a_lo    (w_a_lo),
        .o_a_hi    (w_a_hi),
        .o_b_lo    (w_b_lo),
        .o_b_hi    (w_b_hi)
    );

    lpv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dvd),
        .i_divisor  (r_div_dvs),
        .i_steps    (r_div_steps),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_ovf      (w_ovf)
    );

    assign w_accept    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.drive_value = r_out_val;
    assign o_out.status      = r_out_st;

    assign w_na = (w_cfg.output_order > 4'(lpv_pkg::NA_MAX)) ?
                  4'(lpv_pkg::NA_MAX) : w_cfg.output_order;
    assign w_nb = (w_cfg.input_order > 3'(lpv_pkg::NB_MAX)) ?
                  3'(lpv_pkg::NB_MAX) : w_cfg.input_order;

    always_comb begin
        w_wr.en    = w_accept && ((i_in.mode == lpv_pkg::MODE_COEF_A) ||
                                  (i_in.mode == lpv_pkg::MODE_COEF_B));
        w_wr.sel_b = (i_in.mode == lpv_pkg::MODE_COEF_B);
        w_wr.addr  = {i_in.slot, i_in.coef_index};
        w_wr.data  = i_in.load_value;
    end

    assign w_lv_dly = (i_in.load_value < 0) ? 3'd0 :
                      (i_in.load_value > 32'sd7) ? 3'(lpv_pkg::DLY_MAX) :
                      i_in.load_value[2:0];

    // interpolation datapath
    assign w_v0   = r_j[3] ? w_b_lo : w_a_lo;
    assign w_v1   = r_j[3] ? w_b_hi : w_a_hi;
    assign w_diff = {w_v1[31], w_v1} - {w_v0[31], w_v0};
    assign w_lr   = (r_prod + 64'sd536870912) >>> lpv_pkg::FRAC_W;
    assign w_term = (r_prod + 64'sd32768) >>> 16;

    assign w_ddiff  = $signed({2'b00, r_hi_dly}) - $signed({2'b00, r_lo_dly});
    assign w_dprod  = w_ddiff * $signed({1'b0, r_t});
    assign w_dround = (w_dprod + 37'sd536870912) >>> lpv_pkg::FRAC_W;
    assign w_d      = r_lo_dly + w_dround[2:0];

    assign w_dp   = r_p - r_lo_key;
    assign w_span = r_hi_key - r_lo_key;

    // operand of the current a or b term
    assign w_k    = {1'b0, r_j[2:0]} + 4'd1;
    assign w_hidx = w_k - {1'b0, r_d} - 4'd1;
    assign w_bi   = r_j[2:0];
    assign w_didx = w_bi - 3'd1;
    always_comb begin
        if (!r_j[3]) begin
            w_act = (w_k <= w_na);
            w_yv  = (w_k <= {1'b0, r_d}) ? r_yc : r_th[w_hidx];
        end else begin
            w_act = (w_bi != 3'd0) && (w_bi <= w_nb);
            w_yv  = r_dh[w_didx];
        end
    end

    // quotient sign, magnitude and saturation
    assign w_mag = r_num[lpv_pkg::NUM_W-1] ? lpv_pkg::NUM_W'(-r_num) : r_num;
    assign w_dm  = r_b0[31] ? 32'(-r_b0) : r_b0;
    assign w_big = w_ovf || w_quot[32];
    always_comb begin
        if (r_neg) begin
            w_sat = w_big || (w_quot[31:0] > 32'h8000_0000);
            w_x   = w_sat ? 32'sh8000_0000 : -$signed(w_quot[31:0]);
        end else begin
            w_sat = w_big || w_quot[31];
            w_x   = w_sat ? 32'sh7fff_ffff : $signed(w_quot[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pvalid    <= '0;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
            for (int i = 0; i < lpv_pkg::N_POINTS; i++) begin
                r_pdly[i] <= '0;
            end
            for (int i = 0; i < lpv_pkg::HIST_LEN; i++) begin
                r_th[i] <= '0;
            end
            for (int i = 0; i < lpv_pkg::NB_MAX; i++) begin
                r_dh[i] <= '0;
            end
        end else begin
            // divider launched for the fraction or for the quotient
            r_div_start <= ((r_state == S_PICK) && !r_ex_ok && r_lo_ok && r_hi_ok) ||
                           ((r_state == S_XCHK) && (r_b0 != 32'sd0));
            if ((r_state == S_DONE) && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_val <= '0;
                        r_res_st  <= lpv_pkg::ST_OK;
                        unique case (i_in.mode)
                            lpv_pkg::MODE_SAMPLE: begin
                                r_yc    <= i_in.y_current;
                                r_ya    <= i_in.y_ahead;
                                r_p     <= i_in.sched_param;
                                r_k     <= '0;
                                r_ex_ok <= 1'b0;
                                r_lo_ok <= 1'b0;
                                r_hi_ok <= 1'b0;
                                r_state <= S_SEARCH;
                            end
                            lpv_pkg::MODE_KEY: begin
                                r_key[i_in.slot]    <= i_in.load_value;
                                r_pvalid[i_in.slot] <= 1'b1;
                                r_state             <= S_DONE;
                            end
                            lpv_pkg::MODE_DELAY: begin
                                r_pdly[i_in.slot] <= w_lv_dly;
                                r_state           <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    if (r_pvalid[r_k]) begin
                        if (r_key[r_k] == r_p) begin
                            if (!r_ex_ok) begin
                                r_ex_ok   <= 1'b1;
                                r_ex_slot <= r_k;
                                r_ex_dly  <= r_pdly[r_k];
                            end
                        end else if (r_key[r_k] < r_p) begin
                            if (!r_lo_ok || r_key[r_k] > r_lo_key) begin
                                r_lo_ok   <= 1'b1;
                                r_lo_slot <= r_k;
                                r_lo_key  <= r_key[r_k];
                                r_lo_dly  <= r_pdly[r_k];
                            end
                        end else begin
                            if (!r_hi_ok || r_key[r_k] < r_hi_key) begin
                                r_hi_ok   <= 1'b1;
                                r_hi_slot <= r_k;
                                r_hi_key  <= r_key[r_k];
                                r_hi_dly  <= r_pdly[r_k];
                            end
                        end
                    end
                    if (r_k == lpv_pkg::SLOT_W'(lpv_pkg::N_POINTS - 1)) begin
                        r_state <= S_PICK;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_PICK: begin
                    r_t <= '0;
                    priority if (!r_ex_ok && !r_lo_ok && !r_hi_ok) begin
                        r_res_st <= lpv_pkg::ST_EMPTY;
                        r_state  <= S_DONE;
                    end else if (r_ex_ok) begin
                        r_lo_slot <= r_ex_slot;
                        r_hi_slot <= r_ex_slot;
                        r_lo_dly  <= r_ex_dly;
                        r_hi_dly  <= r_ex_dly;
                        r_state   <= S_DELAY;
                    end else if (!r_lo_ok) begin
                        r_lo_slot <= r_hi_slot;
                        r_lo_dly  <= r_hi_dly;
                        r_state   <= S_DELAY;
                    end else if (!r_hi_ok) begin
                        r_hi_slot <= r_lo_slot;
                        r_hi_dly  <= r_lo_dly;
                        r_state   <= S_DELAY;
                    end else begin
                        // fraction (p - key_lo) / span in q0.30
                        r_div_dvd   <= {w_dp, (lpv_pkg::DVD_W - 32)'(0)};
                        r_div_dvs   <= w_span;
                        r_div_steps <= lpv_pkg::STEP_W'(32 + lpv_pkg::FRAC_W);
                        r_state     <= S_TWAIT;
                    end
                end
                S_TWAIT: begin
                    if (w_div_done) begin
                        r_t     <= w_quot[lpv_pkg::FRAC_W-1:0];
                        r_state <= S_DELAY;
                    end
                end
                S_DELAY: begin
                    r_d     <= w_d;
                    r_len   <= {1'b0, w_na} + {2'b00, w_d};
                    r_j     <= '0;
                    r_num   <= lpv_pkg::NUM_W'(r_ya);
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_LMUL;
                end
                S_LMUL: begin
                    r_prod  <= 64'(w_diff) * 64'($signed({1'b0, r_t}));
                    r_state <= S_LADD;
                end
                S_LADD: begin
                    r_coef  <= w_v0 + w_lr[31:0];
                    r_state <= S_MMUL;
                end
                S_MMUL: begin
                    if (r_j == 4'd8) begin
                        r_b0 <= r_coef;
                    end
                    r_prod  <= r_coef * w_yv;
                    r_act   <= w_act;
                    r_sub   <= r_j[3];
                    r_state <= S_MACC;
                end
                S_MACC: begin
                    if (r_act) begin
                        if (r_sub) begin
                            r_num <= r_num - w_term[lpv_pkg::NUM_W-1:0];
                        end else begin
                            r_num <= r_num + w_term[lpv_pkg::NUM_W-1:0];
                        end
                    end
                    r_j     <= r_j + 4'd1;
                    r_state <= (r_j == 4'd15) ? S_XCHK : S_RD;
                end
                S_XCHK: begin
                    if (r_b0 == 32'sd0) begin
                        // resize histories only
                        for (int i = 0; i < lpv_pkg::HIST_LEN; i++) begin
                            if (5'(i) >= r_len) r_th[i] <= '0;
                        end
                        for (int i = 0; i < lpv_pkg::NB_MAX; i++) begin
                            if (3'(i) >= w_nb) r_dh[i] <= '0;
                        end
                        r_res_st <= lpv_pkg::ST_B0_ZERO;
                        r_state  <= S_DONE;
                    end else begin
                        r_neg       <= r_num[lpv_pkg::NUM_W-1] ^ r_b0[31];
                        r_div_dvd   <= {w_mag, 16'd0};
                        r_div_dvs   <= w_dm;
                        r_div_steps <= lpv_pkg::STEP_W'(lpv_pkg::DVD_W);
                        r_state     <= S_XWAIT;
                    end
                end
                S_XWAIT: begin
                    if (w_div_done) begin
                        for (int i = 0; i < lpv_pkg::HIST_LEN; i++) begin
                            if (5'(i) >= r_len) r_th[i] <= '0;
                            else if (i == 0) r_th[i] <= r_yc;
                            else r_th[i] <= r_th[i-1];
                        end
                        for (int i = 0; i < lpv_pkg::NB_MAX; i++) begin
                            if (3'(i) >= w_nb) r_dh[i] <= '0;
                            else if (i == 0) r_dh[i] <= w_x;
                            else r_dh[i] <= r_dh[i-1];
                        end
                        r_res_val <= w_x;
                        r_res_st  <= w_sat ? lpv_pkg::ST_SAT : lpv_pkg::ST_OK;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_val   <= r_res_val;
                        r_out_st    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_out.ready) |=> (r_state == S_DONE))
        else $error("result register overwritten while still held");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TWAIT) |-> (r_lo_key < r_hi_key))
        else $error("interpolation keys out of order");

    a_div_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> ($past(r_state) == S_PICK || $past(r_state) == S_XCHK))
        else $error("divider started outside a divide step");

    a_no_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XWAIT) |-> (r_b0 != 32'sd0))
        else $error("quotient divide with zero b0");
endmodule
`default_nettype wire

// ===== tb/tb_lpv_inverse_iir_filter_unit.sv =====
// testbench of the gain-scheduled inverse iir filter: directed and random items, scoreboard
`default_nettype none
module tb_lpv_inverse_iir_filter_unit;

    typedef struct {
        logic signed [31:0] drive_value;
        logic [1:0]         status;
    } t_drive_res;

    // behavioral copy of the filter, tables and histories kept in 64-bit signed values
    class filter_scoreboard;
        longint unsigned   out_order;
        longint unsigned   in_order;
        longint            key_tab[lpv_pkg::N_POINTS];
        bit                key_ok[lpv_pkg::N_POINTS];
        longint            dly_tab[lpv_pkg::N_POINTS];
        longint            a_tab[lpv_pkg::N_POINTS][lpv_pkg::NA_MAX];
        longint            b_tab[lpv_pkg::N_POINTS][lpv_pkg::NB_MAX+1];
        longint            y_hist[lpv_pkg::HIST_LEN];
        longint            x_hist[lpv_pkg::NB_MAX+1];
        t_drive_res        pending[$];
        int                n_err;

        function new();
            out_order = 2;
            in_order  = 2;
            n_err     = 0;
            foreach (key_tab[i]) begin
                key_tab[i] = 0;
                key_ok[i]  = 0;
                dly_tab[i] = 0;
                foreach (a_tab[i][j]) a_tab[i][j] = 0;
                foreach (b_tab[i][j]) b_tab[i][j] = 0;
            end
            foreach (y_hist[i]) y_hist[i] = 0;
            foreach (x_hist[i]) x_hist[i] = 0;
        endfunction

        // floor((v + 2^(sh-1)) / 2^sh)
        function longint round_shift(longint v, int sh);
            return (v + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        function longint blend(longint v0, longint v1, longint t);
            return v0 + round_shift((v1 - v0) * t, lpv_pkg::FRAC_W);
        endfunction

        function void note_input(logic [2:0] mode, logic signed [31:0] yc32,
                                 logic signed [31:0] ya32, logic signed [31:0] p32,
                                 logic [2:0] slot, logic [2:0] ci,
                                 logic signed [31:0] lv32);
            t_drive_res r;
            longint yc, ya, p, lv, num, b0, x, t, dd, yv, span, dp;
            longint ca[lpv_pkg::NA_MAX];
            longint cb[lpv_pkg::NB_MAX+1];
            longint unsigned mag, dm, q1, rem;
            int na, nb, lo, hi, ex, d, len;
            bit neg;
            yc = yc32; ya = ya32; p = p32; lv = lv32;
            na = (out_order > lpv_pkg::NA_MAX) ? lpv_pkg::NA_MAX : int'(out_order);
            nb = (in_order > lpv_pkg::NB_MAX) ? lpv_pkg::NB_MAX : int'(in_order);
            lo = -1; hi = -1; ex = -1;
            r.drive_value = '0;
            r.status = lpv_pkg::ST_OK;
            if (mode != lpv_pkg::MODE_SAMPLE) begin
                case (mode)
                    lpv_pkg::MODE_KEY: begin
                        key_tab[slot] = lv;
                        key_ok[slot]  = 1;
                    end
                    lpv_pkg::MODE_DELAY: dly_tab[slot] = lv < 0 ? 0 :
                        (lv > lpv_pkg::DLY_MAX ? lpv_pkg::DLY_MAX : lv);
                    lpv_pkg::MODE_COEF_A: a_tab[slot][ci] = lv;
                    lpv_pkg::MODE_COEF_B: b_tab[slot][ci] = lv;
                    default: ;
                endcase
                pending.insert(pending.size(), r);
                return;
            end
            for (int k = 0; k < lpv_pkg::N_POINTS; k++) begin
                if (!key_ok[k]) continue;
                if (key_tab[k] == p) begin
                    if (ex < 0) ex = k;
                end else if (key_tab[k] < p) begin
                    if (lo < 0 || key_tab[k] > key_tab[lo]) lo = k;
                end else begin
                    if (hi < 0 || key_tab[k] < key_tab[hi]) hi = k;
                end
            end
            if (ex < 0 && lo < 0 && hi < 0) begin
                r.status = lpv_pkg::ST_EMPTY;
                pending.insert(pending.size(), r);
                return;
            end
            if (ex < 0 && (lo < 0 || hi < 0)) ex = (lo < 0) ? hi : lo;
            if (ex >= 0) begin
                for (int k = 0; k < lpv_pkg::NA_MAX; k++) ca[k] = a_tab[ex][k];
                for (int k = 0; k <= lpv_pkg::NB_MAX; k++) cb[k] = b_tab[ex][k];
                d = int'(dly_tab[ex]);
            end else begin
                span = key_tab[hi] - key_tab[lo];
                dp = p - key_tab[lo];
                t = (dp << lpv_pkg::FRAC_W) / span;
                for (int k = 0; k < lpv_pkg::NA_MAX; k++)
                    ca[k] = blend(a_tab[lo][k], a_tab[hi][k], t);
                for (int k = 0; k <= lpv_pkg::NB_MAX; k++)
                    cb[k] = blend(b_tab[lo][k], b_tab[hi][k], t);
                dd = round_shift(dly_tab[lo] * (longint'(1) << lpv_pkg::FRAC_W)
                                 + (dly_tab[hi] - dly_tab[lo]) * t, lpv_pkg::FRAC_W);
                d = int'(dd < 0 ? 0 : (dd > lpv_pkg::DLY_MAX ? lpv_pkg::DLY_MAX : dd));
            end
            len = na + d;
            for (int k = len; k < lpv_pkg::HIST_LEN; k++) y_hist[k] = 0;
            for (int k = nb; k <= lpv_pkg::NB_MAX; k++) x_hist[k] = 0;
            b0 = cb[0];
            if (b0 == 0) begin
                r.status = lpv_pkg::ST_B0_ZERO;
                pending.insert(pending.size(), r);
                return;
            end
            num = ya;
            for (int k = 1; k <= na; k++) begin
                yv = (k <= d) ? yc : y_hist[k - d - 1];
                num += round_shift(ca[k-1] * yv, 16);
            end
            for (int k = 1; k <= nb; k++) num -= round_shift(cb[k] * x_hist[k-1], 16);
            neg = (num < 0) != (b0 < 0);
            mag = (num < 0) ? -num : num;
            dm = (b0 < 0) ? -b0 : b0;
            q1 = mag / dm;
            rem = mag % dm;
            if (q1 >= (64'd1 << 32)) mag = 64'd1 << 40;
            else mag = (q1 << 16) + ((rem << 16) / dm);
            if (neg) begin
                if (mag > 64'h8000_0000) begin
                    mag = 64'h8000_0000;
                    r.status = lpv_pkg::ST_SAT;
                end
                x = -longint'(mag);
            end else begin
                if (mag > 64'h7FFF_FFFF) begin
                    mag = 64'h7FFF_FFFF;
                    r.status = lpv_pkg::ST_SAT;
                end
                x = longint'(mag);
            end
            for (int k = lpv_pkg::HIST_LEN - 1; k > 0; k--) y_hist[k] = y_hist[k-1];
            y_hist[0] = yc;
            for (int k = len; k < lpv_pkg::HIST_LEN; k++) y_hist[k] = 0;
            for (int k = lpv_pkg::NB_MAX; k > 0; k--) x_hist[k] = x_hist[k-1];
            x_hist[0] = x;
            for (int k = nb; k <= lpv_pkg::NB_MAX; k++) x_hist[k] = 0;
            r.drive_value = x[31:0];
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(logic signed [31:0] dv, logic [1:0] st);
            t_drive_res e;
            if (pending.size() == 0) begin
                $error("unexpected result drive_value %0d status %0d", dv, st);
                n_err++;
                return;
            end
            e = pending.pop_front();
            if (dv !== e.drive_value) begin
                $error("drive_value expected %0d actual %0d", e.drive_value, dv);
                n_err++;
            end
            if (st !== e.status) begin
                $error("status expected %0d actual %0d", e.status, st);
                n_err++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [lpv_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    lpv_in_if  in_ch();
    lpv_out_if out_ch();

    lpv_inverse_iir_filter_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    filter_scoreboard sb = new();
    int send_idle = 0;
    int recv_stall = 0;

    initial begin
        in_ch.valid = 0;
        in_ch.mode = lpv_pkg::MODE_SAMPLE;
        in_ch.y_current = '0;
        in_ch.y_ahead = '0;
        in_ch.sched_param = '0;
        in_ch.slot = '0;
        in_ch.coef_index = '0;
        in_ch.load_value = '0;
        out_ch.ready = 0;
    end

    // receiver side: random stalls and result checking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.drive_value, out_ch.status);
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic cfg_write(logic [lpv_pkg::PADDR_W-3:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == lpv_pkg::REG_OUTPUT_ORDER) sb.out_order = val[3:0];
        else sb.in_order = val[2:0];
    endtask

    // valid stays high after a transaction unless the sender idles or drains
    task automatic send_item(logic [2:0] mode, logic signed [31:0] yc, logic signed [31:0] ya,
                             logic signed [31:0] p, logic [2:0] slot, logic [2:0] ci,
                             logic signed [31:0] lv);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.mode <= mode;
        in_ch.y_current <= yc;
        in_ch.y_ahead <= ya;
        in_ch.sched_param <= p;
        in_ch.slot <= slot;
        in_ch.coef_index <= ci;
        in_ch.load_value <= lv;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(mode, yc, ya, p, slot, ci, lv);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rnd_word();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(32'h3FFFF)) - 32'sh1FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] rnd_coef();
        if ($urandom_range(9) == 0) return 0;
        if ($urandom_range(19) == 0) return rnd_word();
        return $signed($urandom_range(32'h3_0000)) - 32'sh1_8000;
    endfunction

    task automatic rnd_load();
        logic [2:0] m;
        m = 3'($urandom_range(lpv_pkg::MODE_COEF_B, lpv_pkg::MODE_KEY));
        if ($urandom_range(49) == 0) m = 3'($urandom_range(7, 5));
        case (m)
            lpv_pkg::MODE_KEY: send_item(m, rnd_word(), rnd_word(), rnd_word(), 3'($urandom),
                                3'($urandom),
                                $urandom_range(3) == 0 ? rnd_word()
                                : 32'($signed($urandom_range(16)) - 8) <<< 16);
            lpv_pkg::MODE_DELAY: send_item(m, rnd_word(), rnd_word(), rnd_word(), 3'($urandom),
                                  3'($urandom),
                                  $urandom_range(4) == 0 ? rnd_word()
                                  : $signed($urandom_range(9)) - 1);
            default: send_item(m, rnd_word(), rnd_word(), rnd_word(), 3'($urandom),
                               3'($urandom), rnd_coef());
        endcase
    endtask

    task automatic rnd_sample();
        logic signed [31:0] p;
        p = ($urandom_range(3) == 0) ? rnd_word()
            : $signed($urandom_range(32'h12_0000)) - 32'sh9_0000;
        if ($urandom_range(5) == 0) p = $signed($urandom_range(16)) - 8 <<< 16;
        send_item(lpv_pkg::MODE_SAMPLE, $urandom_range(7) == 0 ? rnd_word() : rnd_coef(),
                  $urandom_range(7) == 0 ? rnd_word() : rnd_coef(), p, 3'($urandom),
                  3'($urandom), rnd_word());
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty table, loads, exact match, interpolation, extremes
        send_item(lpv_pkg::MODE_SAMPLE, 32'sh1_0000, 32'sh1_0000, 0, 0, 0, 0);
        send_item(lpv_pkg::MODE_KEY, 0, 0, 0, 0, 0, 32'sh0);
        send_item(lpv_pkg::MODE_SAMPLE, 32'sh1_0000, 32'sh1_0000, 0, 0, 0, 0);
        send_item(lpv_pkg::MODE_COEF_B, 0, 0, 0, 0, 0, 32'sh1_0000);
        send_item(lpv_pkg::MODE_COEF_A, 0, 0, 0, 0, 0, 32'sh8000);
        send_item(lpv_pkg::MODE_DELAY, 0, 0, 0, 0, 0, -5);
        send_item(lpv_pkg::MODE_KEY, 0, 0, 0, 7, 0, 32'sh4_0000);
        send_item(lpv_pkg::MODE_COEF_B, 0, 0, 0, 7, 0, 32'sh2_0000);
        send_item(lpv_pkg::MODE_COEF_B, 0, 0, 0, 7, 7, 32'sh7FFF_FFFF);
        send_item(lpv_pkg::MODE_COEF_A, 0, 0, 0, 7, 7, 32'sh8000_0000);
        send_item(lpv_pkg::MODE_DELAY, 0, 0, 0, 7, 0, 100);
        send_item(lpv_pkg::MODE_KEY, 0, 0, 0, 3, 0, 32'sh4_0000);
        send_item(lpv_pkg::MODE_SAMPLE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh4_0000, 0, 0, 0);
        send_item(lpv_pkg::MODE_SAMPLE, 32'sh2_0000, 32'sh3_0000, 32'sh1_8000, 0, 0, 0);
        send_item(lpv_pkg::MODE_SAMPLE, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  0, 0, 0);
        send_item(lpv_pkg::MODE_SAMPLE, 32'sh1_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0);
        send_item(3'd5, 0, 0, 0, 0, 0, -1);
        send_item(3'd7, -1, -1, -1, 7, 7, -1);
        send_item(lpv_pkg::MODE_COEF_B, 0, 0, 0, 3, 0, 0);
        send_item(lpv_pkg::MODE_SAMPLE, 32'sh1_0000, 32'sh1_0000, 32'sh4_0000, 0, 0, 0);
        send_item(lpv_pkg::MODE_SAMPLE, 32'sh1_0000, 32'sh1_0000, 32'sh3_0000, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 51; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 51; end
                default: begin send_idle = 19; recv_stall = 19; end
            endcase
            case (ph)
                0: begin
                    cfg_write(lpv_pkg::REG_OUTPUT_ORDER, 1);
                    cfg_write(lpv_pkg::REG_INPUT_ORDER, 0);
                end
                1: begin
                    cfg_write(lpv_pkg::REG_OUTPUT_ORDER, 8);
                    cfg_write(lpv_pkg::REG_INPUT_ORDER, 7);
                end
                2: begin
                    cfg_write(lpv_pkg::REG_OUTPUT_ORDER, 15);
                    cfg_write(lpv_pkg::REG_INPUT_ORDER, 3);
                end
                3: begin
                    cfg_write(lpv_pkg::REG_OUTPUT_ORDER, 0);
                    cfg_write(lpv_pkg::REG_INPUT_ORDER, 7);
                end
                default: begin
                    cfg_write(lpv_pkg::REG_OUTPUT_ORDER, $urandom_range(15));
                    cfg_write(lpv_pkg::REG_INPUT_ORDER, $urandom_range(7));
                end
            endcase
            for (int n = 0; n < 48; n++) begin
                if ($urandom_range(99) < 35) rnd_load();
                else rnd_sample();
                if (ph == 4 && n == 20) drain();
            end
            drain();
        end
        send_idle = 0;
        recv_stall = 0;
        drain();
        if (sb.n_err == 0)
            $display("tb_lpv_inverse_iir_filter_unit: done, clean");
        else
            $display("tb_lpv_inverse_iir_filter_unit: done, errors");
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_lpv_inverse_iir_filter_unit: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
